// ===== rtl/core/hecm_pkg.sv =====
// Shared types and constants for the HCI event completion matcher.
// Holds payload structs, request/outcome/register codes and the deframer phase type.
// No dependencies.
`default_nettype none

package hecm_pkg;

  // H4 framing and event codes
  localparam logic [7:0] H4_EVENT_IND     = 8'h04;
  localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0e;
  localparam logic [7:0] EVT_CMD_STATUS   = 8'h0f;

  // Events that may be skipped before the wait fails
  localparam int unsigned MAX_SKIPPED = 16;
  localparam int unsigned SKIP_W      = $clog2(MAX_SKIPPED + 1);

  // Smallest parameter length that can carry opcode and status
  localparam logic [7:0] MIN_MATCH_LEN = 8'd4;

  // Request types
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Outcome codes
  localparam logic [2:0] OUT_COMPLETE_OK  = 3'd0;
  localparam logic [2:0] OUT_STATUS_OK    = 3'd1;
  localparam logic [2:0] OUT_RESTART_OK   = 3'd2;
  localparam logic [2:0] OUT_COMPLETE_ERR = 3'd3;
  localparam logic [2:0] OUT_STATUS_ERR   = 3'd4;
  localparam logic [2:0] OUT_TIMEOUT      = 3'd5;
  localparam logic [2:0] OUT_BAD_IND      = 3'd6;
  localparam logic [2:0] OUT_TOO_MANY     = 3'd7;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_AWAITED_OPCODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_MODE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_NORMAL  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_RESTART = 2'd3;

  // Register reset values
  localparam logic [15:0] RST_AWAITED_OPCODE  = 16'h0c03;
  localparam logic [15:0] RST_TIMEOUT_NORMAL  = 16'd2000;
  localparam logic [15:0] RST_TIMEOUT_RESTART = 16'd7000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_IND   = 3'd1,
    PH_CODE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_PARAM = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [7:0] status_byte;
    logic       success;
  } result_t;

endpackage : hecm_pkg

`default_nettype wire

// ===== rtl/core/hci_event_completion_matcher.sv =====
// Top level of the HCI event completion matcher: deframer, matcher and result register.
// Depends on hecm_pkg.
`default_nettype none

// Watches received H4 bytes after a command is sent and reports the event
// that completes the awaited opcode. Each transaction on the input channel is
// a start, a received byte or a millisecond tick. A start (re)arms the wait;
// bytes and ticks seen while not waiting are dropped, as is request type 3.
// Bytes are deframed as indicator 0x04, event code, length and parameters;
// the first four parameters are held. Command Complete (0x0e) matches on
// parameters 1..2 and reports parameter 3 as status; Command Status (0x0f)
// matches on parameters 2..3 and reports parameter 0. Any other event is
// skipped, and sixteen skipped events end the wait with "too many events".
// A tick that finds the idle count already at the allowed gap ends the wait
// with a timeout, and a first byte other than 0x04 ends it with a bad
// indicator; in restart mode both of those report "restart accepted" as a
// success and the restart timeout applies. At most one result transaction
// follows an input transaction, and only when a wait ends.
// Rate: one input transaction per clock while input stall is low. Each transaction is
// handled in the cycle it is accepted and its result lands in the output
// register at that edge, so a result shows in the cycle after its input. The
// output register is the only thing that holds the input back: input stall
// is raised while a result sits in it and the output side stalls.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect with the next input transaction.
module hci_event_completion_matcher (
  input  wire                                 clk,
  input  wire                                 rst,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire hecm_pkg::req_t                 in_data,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output hecm_pkg::result_t                   out_data,
  // configuration write port
  input  wire                                 cfg_we,
  input  wire [hecm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [hecm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [15:0] awaited_opcode;
  logic        restart_mode;
  logic [15:0] timeout_normal;
  logic [15:0] timeout_restart;

  // Wait and deframer state
  hecm_pkg::phase_t             phase, phase_next;
  logic [7:0]                   event_code, event_code_next;
  logic [7:0]                   param_length, param_length_next;
  logic [7:0]                   param_index, param_index_next;
  logic [3:0][7:0]              first_params, first_params_next;
  logic [15:0]                  idle_ticks, idle_ticks_next;
  logic [hecm_pkg::SKIP_W-1:0]  skipped_events, skipped_events_next;

  // Result produced by the current transaction
  logic              res_valid;
  hecm_pkg::result_t res;

  logic        in_accept;
  logic [15:0] gap_limit;
  logic        ev_done;
  logic [7:0]  ev_len;
  logic [hecm_pkg::SKIP_W-1:0] skip_inc;

  // Take a new transaction unless a result is parked and the output side stalls.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign gap_limit = restart_mode ? timeout_restart : timeout_normal;
  assign skip_inc  = skipped_events + hecm_pkg::SKIP_W'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      awaited_opcode  <= hecm_pkg::RST_AWAITED_OPCODE;
      restart_mode    <= 1'b0;
      timeout_normal  <= hecm_pkg::RST_TIMEOUT_NORMAL;
      timeout_restart <= hecm_pkg::RST_TIMEOUT_RESTART;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hecm_pkg::CFG_AWAITED_OPCODE:  awaited_opcode  <= cfg_data;
        hecm_pkg::CFG_RESTART_MODE:    restart_mode    <= cfg_data[0];
        hecm_pkg::CFG_TIMEOUT_NORMAL:  timeout_normal  <= cfg_data;
        hecm_pkg::CFG_TIMEOUT_RESTART: timeout_restart <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and result for the accepted transaction
  always_comb begin
    phase_next          = phase;
    event_code_next     = event_code;
    param_length_next   = param_length;
    param_index_next    = param_index;
    first_params_next   = first_params;
    idle_ticks_next     = idle_ticks;
    skipped_events_next = skipped_events;
    res_valid           = 1'b0;
    res                 = '0;
    ev_done             = 1'b0;
    ev_len              = param_length;

    if (in_accept) begin
      if (in_data.req_type == hecm_pkg::REQ_START) begin
        // Arm a fresh wait; drop any partial event.
        phase_next          = hecm_pkg::PH_IND;
        event_code_next     = '0;
        param_length_next   = '0;
        param_index_next    = '0;
        first_params_next   = '0;
        idle_ticks_next     = '0;
        skipped_events_next = '0;
      end else if (phase != hecm_pkg::PH_IDLE &&
                   in_data.req_type == hecm_pkg::REQ_TICK) begin
        if (idle_ticks >= gap_limit) begin
          res_valid       = 1'b1;
          res.outcome     = restart_mode ? hecm_pkg::OUT_RESTART_OK : hecm_pkg::OUT_TIMEOUT;
          res.success     = restart_mode;
          phase_next      = hecm_pkg::PH_IDLE;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end else if (phase != hecm_pkg::PH_IDLE &&
                   in_data.req_type == hecm_pkg::REQ_BYTE) begin
        idle_ticks_next = '0;
        unique case (phase)
          hecm_pkg::PH_IND: begin
            if (in_data.rx_byte != hecm_pkg::H4_EVENT_IND) begin
              res_valid   = 1'b1;
              res.outcome = restart_mode ? hecm_pkg::OUT_RESTART_OK : hecm_pkg::OUT_BAD_IND;
              res.success = restart_mode;
              phase_next  = hecm_pkg::PH_IDLE;
            end else begin
              phase_next  = hecm_pkg::PH_CODE;
            end
          end
          hecm_pkg::PH_CODE: begin
            event_code_next = in_data.rx_byte;
            phase_next      = hecm_pkg::PH_LEN;
          end
          hecm_pkg::PH_LEN: begin
            param_length_next = in_data.rx_byte;
            param_index_next  = '0;
            ev_len            = in_data.rx_byte;
            if (in_data.rx_byte == 8'd0) begin
              ev_done    = 1'b1;
            end else begin
              phase_next = hecm_pkg::PH_PARAM;
            end
          end
          hecm_pkg::PH_PARAM: begin
            // Keep the first four parameters only.
            if (param_index < 8'd4) begin
              first_params_next[param_index[1:0]] = in_data.rx_byte;
            end
            param_index_next = param_index + 8'd1;
            if (param_index_next >= param_length) begin
              ev_done = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // End of one event: match on the opcode, else skip it.
    if (ev_done) begin
      if (event_code == hecm_pkg::EVT_CMD_COMPLETE && ev_len >= hecm_pkg::MIN_MATCH_LEN &&
          first_params_next[1] == awaited_opcode[7:0] &&
          first_params_next[2] == awaited_opcode[15:8]) begin
        res_valid       = 1'b1;
        res.status_byte = first_params_next[3];
        res.success     = (first_params_next[3] == 8'd0);
        res.outcome     = res.success ? hecm_pkg::OUT_COMPLETE_OK : hecm_pkg::OUT_COMPLETE_ERR;
        phase_next      = hecm_pkg::PH_IDLE;
      end else if (event_code == hecm_pkg::EVT_CMD_STATUS &&
                   ev_len >= hecm_pkg::MIN_MATCH_LEN &&
                   first_params_next[2] == awaited_opcode[7:0] &&
                   first_params_next[3] == awaited_opcode[15:8]) begin
        res_valid       = 1'b1;
        res.status_byte = first_params_next[0];
        res.success     = (first_params_next[0] == 8'd0);
        res.outcome     = res.success ? hecm_pkg::OUT_STATUS_OK : hecm_pkg::OUT_STATUS_ERR;
        phase_next      = hecm_pkg::PH_IDLE;
      end else begin
        skipped_events_next = skip_inc;
        if (skip_inc >= hecm_pkg::SKIP_W'(hecm_pkg::MAX_SKIPPED)) begin
          res_valid   = 1'b1;
          res.outcome = hecm_pkg::OUT_TOO_MANY;
          phase_next  = hecm_pkg::PH_IDLE;
        end else begin
          phase_next        = hecm_pkg::PH_IND;
          param_index_next  = '0;
          first_params_next = '0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hecm_pkg::PH_IDLE;
      event_code     <= '0;
      param_length   <= '0;
      param_index    <= '0;
      first_params   <= '0;
      idle_ticks     <= '0;
      skipped_events <= '0;
    end else begin
      phase          <= phase_next;
      event_code     <= event_code_next;
      param_length   <= param_length_next;
      param_index    <= param_index_next;
      first_params   <= first_params_next;
      idle_ticks     <= idle_ticks_next;
      skipped_events <= skipped_events_next;
    end
  end

  // Output register: load a new result, drop one once taken, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule : hci_event_completion_matcher

`default_nettype wire

// ===== rtl/core/hecm_checker.sv =====
// Port-level checker for the HCI event completion matcher, bound to the top level.
// Depends on hecm_pkg and hci_event_completion_matcher.
`default_nettype none

module hecm_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire hecm_pkg::result_t           out_data
);

  // A parked result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // A stalled result must hold the input back.
  a_in_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result register is blocked");

  // A result only follows an accepted transaction.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted transaction");

  // Success flag agrees with the outcome code.
  a_success_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.success ==
      (out_data.outcome == hecm_pkg::OUT_COMPLETE_OK ||
       out_data.outcome == hecm_pkg::OUT_STATUS_OK ||
       out_data.outcome == hecm_pkg::OUT_RESTART_OK))
    else $error("success flag does not match outcome");

  // Outcomes without a matched event carry a zero status.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.outcome == hecm_pkg::OUT_RESTART_OK ||
                  out_data.outcome == hecm_pkg::OUT_TIMEOUT ||
                  out_data.outcome == hecm_pkg::OUT_BAD_IND ||
                  out_data.outcome == hecm_pkg::OUT_TOO_MANY)
      |-> out_data.status_byte == 8'd0)
    else $error("nonzero status on an unmatched outcome");

endmodule : hecm_checker

bind hci_event_completion_matcher hecm_checker u_hecm_checker (.*);

`default_nettype wire
